// File: hw/rtl/hfsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heater and fan serial command handler.
// Depends on nothing; every other file imports it.
package hfsc_pkg;

	// Command bytes; anything below CMD_ID is a data byte
	localparam logic [7:0] CMD_ID    = 8'd252;
	localparam logic [7:0] CMD_FAN   = 8'd253;
	localparam logic [7:0] CMD_HEAT  = 8'd254;
	localparam logic [7:0] CMD_TEMP  = 8'd255;

	localparam logic [5:0] HEAT_MAX   = 6'd40;
	localparam logic [7:0] FAN_MAX    = 8'd251;
	localparam logic [7:0] FAN_RESET  = 8'd252;
	localparam logic [7:0] ID_RESET   = 8'd15;

	// Fixed-point reciprocals, 16 fraction bits: 40/100, 251/100 and 1/10
	localparam logic [17:0] HEAT_RECIP = 18'd26215;
	localparam logic [17:0] FAN_RECIP  = 18'd164496;
	localparam logic [12:0] TEMP_RECIP = 13'd6554;
	localparam logic [10:0] TEN        = 11'd10;

	// Number of results that follow the first one on a temperature request
	localparam logic [2:0] TEMP_TAIL = 3'd5;

	typedef struct packed {
		logic [7:0]  rx_byte;
		logic [10:0] temperature_reading;
	} item_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        last_of_run;
		logic [5:0]  heater_duty;
		logic [7:0]  fan_duty;
	} result_t;

	// Decoded request handed from the command stage to the transmit sequencer
	typedef struct packed {
		logic        send;
		logic        is_temp;
		logic [7:0]  first_byte;
		logic [7:0]  quo;
		logic [10:0] temp;
		logic [5:0]  heater;
		logic [7:0]  fan;
	} desc_t;

endpackage

// File: hw/rtl/hfsc_cmd.sv
`timescale 1ns / 1ps
// Command decoder: arming flags, duty registers, machine ID register.
// Uses hfsc_pkg for the item and descriptor types and the command codes.
module hfsc_cmd import hfsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       load,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	output desc_t      desc
);

	logic        arm_heat_q;
	logic        arm_fan_q;
	logic [5:0]  heat_q;
	logic [7:0]  fan_q;
	logic [7:0]  id_q;

	logic [7:0]  rx;
	logic        is_data;
	logic [25:0] heat_prod;
	logic [25:0] fan_prod;
	logic [23:0] temp_prod;
	logic [9:0]  heat_quo;
	logic [9:0]  fan_quo;
	logic [5:0]  heat_new;
	logic [7:0]  fan_new;
	logic [7:0]  temp_quo;

	assign rx      = item.rx_byte;
	assign is_data = rx < CMD_ID;

	assign heat_prod = {18'd0, rx} * {8'd0, HEAT_RECIP};
	assign fan_prod  = {18'd0, rx} * {8'd0, FAN_RECIP};
	assign temp_prod = {13'd0, item.temperature_reading} * {11'd0, TEMP_RECIP};
	assign heat_quo  = heat_prod[25:16];
	assign fan_quo   = fan_prod[25:16];
	assign temp_quo  = temp_prod[23:16];

	// Clamp both duties to their PWM limits
	assign heat_new = (heat_quo > {4'd0, HEAT_MAX}) ? HEAT_MAX : heat_quo[5:0];
	assign fan_new  = (fan_quo > {2'd0, FAN_MAX}) ? FAN_MAX : fan_quo[7:0];

	always_comb begin
		desc.send       = (rx == CMD_ID) || (rx == CMD_TEMP);
		desc.is_temp    = rx == CMD_TEMP;
		desc.quo        = temp_quo;
		desc.temp       = item.temperature_reading;
		desc.heater     = (is_data && arm_heat_q) ? heat_new : heat_q;
		desc.fan        = (is_data && arm_fan_q) ? fan_new : fan_q;
		priority if (rx == CMD_ID) begin
			desc.first_byte = id_q;
		end else if (rx == CMD_TEMP) begin
			desc.first_byte = temp_quo;
		end else begin
			desc.first_byte = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_heat_q <= 1'b0;
			arm_fan_q  <= 1'b0;
			heat_q     <= 6'd0;
			fan_q      <= FAN_RESET;
			id_q       <= ID_RESET;
		end else begin
			if (cfg_we) begin
				id_q <= cfg_data;
			end
			if (load) begin
				// ID and temperature requests leave the arming as it is
				if (is_data) begin
					if (arm_heat_q) begin
						heat_q     <= heat_new;
						arm_heat_q <= 1'b0;
					end
					if (arm_fan_q) begin
						fan_q     <= fan_new;
						arm_fan_q <= 1'b0;
					end
				end else if (rx == CMD_HEAT) begin
					arm_heat_q <= 1'b1;
					arm_fan_q  <= 1'b0;
				end else if (rx == CMD_FAN) begin
					arm_heat_q <= 1'b0;
					arm_fan_q  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hw/rtl/hfsc_tx.sv
`timescale 1ns / 1ps
// Transmit sequencer: result register plus the repeat counter for temperature replies.
// Uses hfsc_pkg for the descriptor and result types.
module hfsc_tx import hfsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load_req,
	input  desc_t   desc,
	output logic    load_ok,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic        vld_q;
	logic [2:0]  left_q;
	logic [7:0]  quo_q;
	logic [10:0] temp_q;
	result_t     res_q;

	logic        advance;
	logic        load;
	logic [10:0] quo_x10;
	logic [10:0] rem_full;

	assign advance = vld_q && !result_stall;
	assign load_ok = !vld_q || (advance && (left_q == 3'd0));
	assign load    = load_req && load_ok;

	assign quo_x10  = {3'd0, quo_q} * TEN;
	assign rem_full = temp_q - quo_x10;

	assign result_valid = vld_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			left_q <= 3'd0;
		end else if (load) begin
			vld_q  <= 1'b1;
			left_q <= desc.is_temp ? TEMP_TAIL : 3'd0;
		end else if (advance) begin
			if (left_q == 3'd0) begin
				vld_q <= 1'b0;
			end else begin
				left_q <= left_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q             <= desc.quo;
			temp_q            <= desc.temp;
			res_q.send_valid  <= desc.send;
			res_q.send_byte   <= desc.first_byte;
			res_q.last_of_run <= !desc.is_temp;
			res_q.heater_duty <= desc.heater;
			res_q.fan_duty    <= desc.fan;
		end else if (advance && (left_q != 3'd0)) begin
			// alternate quotient and remainder; odd count left means remainder next
			res_q.send_byte   <= left_q[0] ? {4'd0, rem_full[3:0]} : quo_q;
			res_q.last_of_run <= left_q == 3'd1;
		end
	end

endmodule

// File: hw/rtl/heater_fan_serial_command_handler_unit.sv
`timescale 1ns / 1ps
// Heater and fan serial command handler, top level. Each received byte is one
// request; it yields one result, or six for a temperature request (255), which
// goes out as quotient, remainder by ten, three times over. A request is taken
// into an input register, decoded combinationally, and loaded into the result
// register; results leave at one per cycle when not stalled, and the transmit
// sequencer issues the repeats of a temperature reply. The next request is
// accepted while a result still waits. The machine ID register (reset 15)
// may be written only while no request is open.
// Uses hfsc_pkg, hfsc_cmd and hfsc_tx.
module heater_fan_serial_command_handler_unit import hfsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item,
	output logic       result_valid,
	input  logic       result_stall,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic  vld_s1;
	item_t item_s1;
	logic  load_ok;
	logic  load;
	desc_t desc;

	assign cfg_ready  = 1'b1;
	assign item_stall = vld_s1 && !load_ok;
	assign load       = vld_s1 && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	hfsc_cmd u_cmd (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_s1),
		.load     (load),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.desc     (desc)
	);

	hfsc_tx u_tx (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_req     (vld_s1),
		.desc         (desc),
		.load_ok      (load_ok),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/hfsc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the command handler, bound to the top level.
// Uses hfsc_pkg for the result type and duty limits.
module hfsc_checker import hfsc_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_silent_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.send_valid |->
		result.last_of_run && (result.send_byte == 8'd0))
		else $error("silent result is not a single empty result");

	a_heater_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.heater_duty <= HEAT_MAX)
		else $error("heater duty above limit");

	a_fan_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.fan_duty <= FAN_RESET)
		else $error("fan duty out of range");

endmodule

bind heater_fan_serial_command_handler_unit hfsc_checker u_hfsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// File: dv/tb_heater_fan_serial_command_handler_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for heater_fan_serial_command_handler_unit: directed and
// random serial bytes, varied machine IDs, random sender gaps and receiver stalls.
// Depends on hfsc_pkg and the handler RTL only.
module tb_heater_fan_serial_command_handler_unit import hfsc_pkg::*; ();

	localparam int CYCLE_LIMIT = 200000;

	// Tracks arming and duty state and holds the results each accepted byte should give
	class cmd_scoreboard;
		bit          arm_heater;
		bit          arm_fan;
		logic [5:0]  heater_level;
		logic [7:0]  fan_level;
		logic [7:0]  machine_id;
		result_t     expected_q[$];
		int          errors;

		function new();
			arm_heater   = 1'b0;
			arm_fan      = 1'b0;
			heater_level = '0;
			fan_level    = FAN_RESET;
			machine_id   = ID_RESET;
			errors       = 0;
		endfunction

		function void set_machine_id(logic [7:0] v);
			machine_id = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void push_result(bit v, logic [7:0] b, bit last);
			result_t r;
			r.send_valid  = v;
			r.send_byte   = b;
			r.last_of_run = last;
			r.heater_duty = heater_level;
			r.fan_duty    = fan_level;
			expected_q.push_back(r);
		endfunction

		function void note_request(item_t it);
			int unsigned b;
			int unsigned t;
			int unsigned duty;
			b = it.rx_byte;
			t = it.temperature_reading;
			if (it.rx_byte < CMD_ID) begin
				if (arm_heater) begin
					duty = b * 40 / 100;
					heater_level = (duty > HEAT_MAX) ? HEAT_MAX : duty[5:0];
					arm_heater = 1'b0;
				end
				if (arm_fan) begin
					duty = b * 251 / 100;
					fan_level = (duty > FAN_MAX) ? FAN_MAX : duty[7:0];
					arm_fan = 1'b0;
				end
			end else if (it.rx_byte == CMD_HEAT) begin
				arm_heater = 1'b1;
				arm_fan    = 1'b0;
			end else if (it.rx_byte == CMD_FAN) begin
				arm_heater = 1'b0;
				arm_fan    = 1'b1;
			end else if (it.rx_byte == CMD_ID) begin
				push_result(1'b1, machine_id, 1'b1);
				return;
			end else begin
				// temperature goes out as quotient, remainder, three times
				for (int k = 0; k < 3; k++) begin
					push_result(1'b1, 8'(t / 10), 1'b0);
					push_result(1'b1, 8'(t % 10), k == 2);
				end
				return;
			end
			push_result(1'b0, 8'd0, 1'b1);
		endfunction

		task report_mismatch(string what, int got, int want);
			$display("ERROR %s: got %0d, expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with nothing expected, send_byte", got.send_byte, 0);
				return;
			end
			want = expected_q.pop_front();
			if (got.send_valid !== want.send_valid)
				report_mismatch("send_valid", got.send_valid, want.send_valid);
			if (got.send_byte !== want.send_byte)
				report_mismatch("send_byte", got.send_byte, want.send_byte);
			if (got.last_of_run !== want.last_of_run)
				report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
			if (got.heater_duty !== want.heater_duty)
				report_mismatch("heater_duty", got.heater_duty, want.heater_duty);
			if (got.fan_duty !== want.fan_duty)
				report_mismatch("fan_duty", got.fan_duty, want.fan_duty);
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = '0;

	int         idle_pct = 0;
	int         stall_pct = 0;
	int         cycles = 0;
	cmd_scoreboard book = new();

	heater_fan_serial_command_handler_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_stall <= 1'b0;
		else
			result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			book.check_result(result);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [10:0] rand_temp();
		// mostly in range, now and then anything the field holds
		if ($urandom_range(9) == 0)
			return 11'($urandom_range(2047));
		return 11'($urandom_range(1189));
	endfunction

	task automatic send_request(input logic [7:0] b, input logic [10:0] t);
		item_t it;
		it.rx_byte = b;
		it.temperature_reading = t;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		book.note_request(it);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	// Hold off the sender until every expected result is back
	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	task automatic write_machine_id(input logic [7:0] v);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.set_machine_id(v);
	endtask

	task automatic run_random(input int n, input int idle, input int stall,
			input logic [7:0] id);
		int sent;
		int pick;
		int pause_at;
		logic [7:0] data;
		sent = 0;
		pause_at = $urandom_range(n - 1);
		drain();
		write_machine_id(id);
		idle_pct = idle;
		stall_pct = stall;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (sent >= pause_at && pause_at >= 0) begin
				drain();
				pause_at = -1;
			end
			if (pick < 45) begin
				case ($urandom_range(4))
					0: data = 8'd0;
					1: data = 8'd251;
					2: data = 8'd100;
					default: data = 8'($urandom_range(251));
				endcase
				send_request($urandom_range(1) ? CMD_HEAT : CMD_FAN, rand_temp());
				send_request(data, rand_temp());
				sent += 2;
			end else if (pick < 60) begin
				send_request(CMD_TEMP, rand_temp());
				sent++;
			end else if (pick < 72) begin
				send_request(CMD_ID, rand_temp());
				sent++;
			end else if (pick < 82) begin
				// arming followed by a command byte instead of data
				send_request($urandom_range(1) ? CMD_HEAT : CMD_FAN, rand_temp());
				send_request(8'($urandom_range(252, 255)), rand_temp());
				sent += 2;
			end else begin
				send_request(8'($urandom_range(255)), rand_temp());
				sent++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: ID 15, heater off, fan full
		send_request(CMD_ID, 11'd0);
		send_request(CMD_TEMP, 11'd0);
		send_request(CMD_TEMP, 11'd2047);
		send_request(CMD_TEMP, 11'd1189);
		send_request(8'd0, 11'd9);
		send_request(8'd251, rand_temp());
		// heater: zero, cap, just below the cap
		send_request(CMD_HEAT, rand_temp());
		send_request(8'd0, rand_temp());
		send_request(CMD_HEAT, rand_temp());
		send_request(8'd251, rand_temp());
		send_request(CMD_HEAT, rand_temp());
		send_request(8'd99, rand_temp());
		// fan: saturation and plain values
		send_request(CMD_FAN, rand_temp());
		send_request(8'd251, rand_temp());
		send_request(CMD_FAN, rand_temp());
		send_request(8'd99, rand_temp());
		send_request(CMD_FAN, rand_temp());
		send_request(8'd0, rand_temp());
		// fan arming clears heater arming; ID and temperature keep the arming
		send_request(CMD_HEAT, rand_temp());
		send_request(CMD_FAN, rand_temp());
		send_request(CMD_ID, rand_temp());
		send_request(CMD_TEMP, 11'd1023);
		send_request(8'd40, rand_temp());
		send_request(8'd250, rand_temp());

		run_random(19, 0, 0, 8'h00);
		run_random(19, 68, 0, 8'hFF);
		run_random(19, 0, 68, 8'($urandom_range(255)));
		run_random(19, 14, 14, 8'($urandom_range(255)));

		drain();
		repeat (20) @(posedge clk);
		if (book.pending() != 0)
			book.report_mismatch("results still expected", book.pending(), 0);
		if (book.errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/hfsc_pkg.sv
hw/rtl/hfsc_cmd.sv
hw/rtl/hfsc_tx.sv
hw/rtl/heater_fan_serial_command_handler_unit.sv
hw/rtl/hfsc_checker.sv
dv/tb_heater_fan_serial_command_handler_unit.sv
